[sv/u8v_pkg.sv]
`default_nettype none

package u8v_pkg;

   // depth of the queue between the classifier and the decoder
   localparam int QueueDepth = 2;

   // byte kinds as seen outside a sequence
   localparam logic [2:0] KIND_ASCII = 3'd0;
   localparam logic [2:0] KIND_LEAD2 = 3'd1;
   localparam logic [2:0] KIND_LEAD3 = 3'd2;
   localparam logic [2:0] KIND_LEAD4 = 3'd3;
   localparam logic [2:0] KIND_BAD   = 3'd4;

   // code point limits
   localparam logic [20:0] CP_MIN_LEN3  = 21'h000800;
   localparam logic [20:0] CP_MIN_LEN4  = 21'h010000;
   localparam logic [20:0] CP_MAX       = 21'h10ffff;
   localparam logic [20:0] CP_SURR_LOW  = 21'h00d800;
   localparam logic [20:0] CP_SURR_HIGH = 21'h00dfff;

   // one classified word handed from the front to the back
   typedef struct packed {
      logic       last;
      logic       is_cont;
      logic [2:0] kind;
      logic [5:0] payload;
   } byte_class_type;

endpackage

`default_nettype wire

[sv/u8v_classify.sv]
`default_nettype none

module u8v_classify
   import u8v_pkg::*;
(
   input  wire logic [7:0]     data_byte,
   input  wire logic           last_byte,
   output byte_class_type      item
);

   logic       is_cont;
   logic [2:0] kind;
   logic [5:0] payload;

   // lead decode and payload bits
   always_comb begin
      is_cont = (data_byte[7:6] == 2'b10);
      kind    = KIND_BAD;
      payload = data_byte[5:0];
      if (!data_byte[7]) begin
         kind = KIND_ASCII;
      end else if (data_byte[7:5] == 3'b110) begin
         if (data_byte[4:1] != 4'd0) begin
            kind    = KIND_LEAD2;
            payload = {1'b0, data_byte[4:0]};
         end
      end else if (data_byte[7:4] == 4'b1110) begin
         kind    = KIND_LEAD3;
         payload = {2'b00, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
         kind    = KIND_LEAD4;
         payload = {3'b000, data_byte[2:0]};
      end
   end

   assign item = '{last: last_byte, is_cont: is_cont, kind: kind, payload: payload};

endmodule

`default_nettype wire

[sv/u8v_queue.sv]
`default_nettype none

module u8v_queue
   import u8v_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire byte_class_type push_item,
   output logic                full,
   input  wire logic           pop,
   output logic                not_empty,
   output byte_class_type      head_item
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   byte_class_type          slot_ff [DEPTH];
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]         count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[sv/u8v_decode.sv]
`default_nettype none

module u8v_decode
   import u8v_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire byte_class_type in_item,
   output logic                in_take,
   output logic                out_valid,
   input  wire logic           out_ready,
   output logic                out_error,
   output logic                out_done,
   output logic                out_ok
);

   logic [1:0]  pend_ff, pend_in;
   logic [1:0]  len_ff, len_in;
   logic [20:0] acc_ff, acc_in;
   logic        err_ff, err_in;
   logic        valid_ff, valid_in;
   logic        error_ff, error_in;
   logic        done_ff, done_in;
   logic        ok_ff, ok_in;
   logic [20:0] cp;
   logic        cp_bad;

   assign in_take   = in_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_error = error_ff;
   assign out_done  = done_ff;
   assign out_ok    = ok_ff;

   // code point with this continuation shifted in, and its range checks
   always_comb begin
      cp     = {acc_ff[14:0], in_item.payload};
      cp_bad = ((len_ff == 2'd2) && (cp < CP_MIN_LEN3))
            || ((len_ff == 2'd3) && (cp < CP_MIN_LEN4))
            || (cp > CP_MAX)
            || ((cp >= CP_SURR_LOW) && (cp <= CP_SURR_HIGH));
   end

   // sequence state machine
   always_comb begin
      pend_in  = pend_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      err_in   = err_ff;
      valid_in = valid_ff && !out_ready;
      error_in = error_ff;
      done_in  = done_ff;
      ok_in    = ok_ff;
      if (in_take) begin
         if (pend_ff == 2'd0) begin
            case (in_item.kind)
               KIND_ASCII: ;
               KIND_LEAD2: begin
                  pend_in = 2'd1;
                  len_in  = 2'd1;
                  acc_in  = 21'(in_item.payload);
               end
               KIND_LEAD3: begin
                  pend_in = 2'd2;
                  len_in  = 2'd2;
                  acc_in  = 21'(in_item.payload);
               end
               KIND_LEAD4: begin
                  pend_in = 2'd3;
                  len_in  = 2'd3;
                  acc_in  = 21'(in_item.payload);
               end
               default: err_in = 1'b1;
            endcase
         end else if (!in_item.is_cont) begin
            err_in  = 1'b1;
            pend_in = 2'd0;
            len_in  = 2'd0;
            acc_in  = '0;
         end else begin
            pend_in = pend_ff - 2'd1;
            acc_in  = cp;
            if (pend_ff == 2'd1) begin
               if (cp_bad) begin
                  err_in = 1'b1;
               end
               len_in = 2'd0;
               acc_in = '0;
            end
         end
         // a sequence cut off by the end of the message
         if (in_item.last && (pend_in != 2'd0)) begin
            err_in = 1'b1;
         end
         valid_in = 1'b1;
         error_in = err_in;
         done_in  = in_item.last;
         ok_in    = in_item.last && !err_in;
         // message end clears the sequence state
         if (in_item.last) begin
            pend_in = 2'd0;
            len_in  = 2'd0;
            acc_in  = '0;
            err_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         err_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         err_ff   <= err_in;
         valid_ff <= valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      error_ff <= error_in;
      done_ff  <= done_in;
      ok_ff    <= ok_in;
   end

endmodule

`default_nettype wire

[sv/utf8_stream_validator.sv]
// UTF-8 stream validator.
// The req channel takes one message byte per word in req_tdata, with req_tlast
// on the final byte of a message. The rsp channel returns one word for every
// byte: rsp_tdata[0] is the sticky error flag of the message so far,
// rsp_tdata[1] is set on the final word when the whole message is valid, and
// rsp_tlast marks the word for the final byte.
// A classifier decodes each byte as it is accepted and writes it into a
// two-entry queue; the decoder pops one word per cycle unless the output stalls,
// runs the sequence and code point checks and holds the result in an output
// register. Throughput is one byte per cycle while the receiver does not
// stall. An accepted byte is written into the queue register first, and its
// result word is then loaded into the output register with rsp_tvalid high.
// Reset (synchronous, active high) empties the queue and the output register
// and clears the sequence state. When the receiver stalls, the output register
// holds its word, the queue fills and req_tready falls once it is full; no word
// is lost. After each final byte the decoder state returns to reset values.
`default_nettype none

module utf8_stream_validator
   import u8v_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] error_seen, [1] message_valid, [7:2] zero
   output logic             rsp_tlast
);

   byte_class_type  front_item;
   byte_class_type  head_item;
   logic            q_full;
   logic            q_not_empty;
   logic            q_pop;
   logic            push;
   logic            error_seen;
   logic            message_done;
   logic            message_valid;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   // front: byte classification
   u8v_classify u_classify (
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .item      (front_item)
   );

   u8v_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // back: sequence decode and result register
   u8v_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_item   (head_item),
      .in_take   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_error (error_seen),
      .out_done  (message_done),
      .out_ok    (message_valid)
   );

   assign rsp_tdata = {6'd0, message_valid, error_seen};
   assign rsp_tlast = message_done;

endmodule

`default_nettype wire
